### rtl/core/ael_pkg.sv
// Shared types and constants of the arithmetic expression lexer.
// Token kinds, scanner modes, character codes and the queue entry format.
// No dependencies.
`default_nettype none

package ael_pkg;

  // Default width of the source position counter
  localparam int AEL_POS_WIDTH = 16;
  // Default token queue depth (two tokens per character at most)
  localparam int AEL_QUEUE_DEPTH = 4;
  // Width of the start and length fields
  localparam int TOK_W = 16;
  // Largest token length reported
  localparam int LEN_MAX = 65535;

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    KIND_LPAREN = 3'd0,
    KIND_RPAREN = 3'd1,
    KIND_PLUS   = 3'd2,
    KIND_MINUS  = 3'd3,
    KIND_MULT   = 3'd4,
    KIND_DIV    = 3'd5,
    KIND_POW    = 3'd6,
    KIND_NUM    = 3'd7
  } kind_e;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_STAR    = 5'b00010,
    MODE_INT     = 5'b00100,
    MODE_INT_DOT = 5'b01000,
    MODE_FRAC    = 5'b10000
  } mode_e;

  typedef struct packed {
    kind_e            kind;
    logic [TOK_W-1:0] start;
    logic [TOK_W-1:0] length;
    logic             run_last;
  } token_t;

  // Tokens produced by one character, in order
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

`default_nettype wire

### rtl/core/ael_scan.sv
// Character scanner: mode/position state and per-character token decode.
// Produces up to two tokens per accepted character. Uses ael_pkg.
`default_nettype none

module ael_scan
  import ael_pkg::*;
#(
  parameter int POS_WIDTH = AEL_POS_WIDTH
) (
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic       accept_i,
  input  wire  logic [7:0] char_i,
  input  wire  logic       is_last_i,
  output push_t            push_o
);

  mode_e                mode_q, mode_d, mode_mid;
  logic [POS_WIDTH-1:0] pend_q, pend_d, pos_q, pos_d;
  logic [POS_WIDTH-1:0] s_mid, dp, dp_mid;
  logic [POS_WIDTH:0]   raw_eq, raw_dn, raw_eq_mid, raw_up_mid;
  logic                 consumed, digit_hit;
  logic                 va, vb, vc;
  token_t               ta, tb, tc;
  logic [1:0]           cnt;

  function automatic logic [TOK_W-1:0] clamp_len(input logic [POS_WIDTH:0] raw);
    logic [TOK_W-1:0] r;
    if (raw == '0) begin
      r = TOK_W'(1);
    end else if (33'(raw) > 33'(LEN_MAX)) begin
      r = TOK_W'(LEN_MAX);
    end else begin
      r = TOK_W'(raw);
    end
    return r;
  endfunction

  assign digit_hit  = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign dp         = pos_q - pend_q;
  assign raw_eq     = {1'b0, dp};
  assign raw_dn     = (dp == '0) ? '0 : ({1'b0, dp} - 1'b1);
  assign dp_mid     = pos_q - s_mid;
  assign raw_eq_mid = {1'b0, dp_mid};
  assign raw_up_mid = {1'b0, dp_mid} + 1'b1;

  always_comb begin
    mode_mid = MODE_IDLE;
    s_mid    = pend_q;
    consumed = 1'b0;
    va       = 1'b0;
    vb       = 1'b0;
    ta       = '{kind: KIND_NUM, start: TOK_W'(pend_q), length: TOK_W'(1), run_last: 1'b0};
    tb       = '{kind: KIND_NUM, start: TOK_W'(pos_q), length: TOK_W'(1), run_last: 1'b0};

    // Close or extend the held token
    unique case (mode_q)
      MODE_STAR: begin
        va = 1'b1;
        if (char_i == CH_STAR) begin
          ta.kind   = KIND_POW;
          ta.length = TOK_W'(2);
          consumed  = 1'b1;
        end else begin
          ta.kind = KIND_MULT;
        end
      end
      MODE_INT: begin
        if (digit_hit) begin
          consumed = 1'b1;
          mode_mid = MODE_INT;
        end else if (char_i == CH_DOT) begin
          consumed = 1'b1;
          mode_mid = MODE_INT_DOT;
        end else begin
          va        = 1'b1;
          ta.length = clamp_len(raw_eq);
        end
      end
      MODE_INT_DOT: begin
        if (digit_hit) begin
          consumed = 1'b1;
          mode_mid = MODE_FRAC;
        end else begin
          // dot was not part of the number
          va        = 1'b1;
          ta.length = clamp_len(raw_dn);
        end
      end
      MODE_FRAC: begin
        if (digit_hit) begin
          consumed = 1'b1;
          mode_mid = MODE_FRAC;
        end else begin
          va        = 1'b1;
          ta.length = clamp_len(raw_eq);
        end
      end
      default: ;
    endcase

    // Scan the character afresh
    if (!consumed) begin
      priority if (char_i == CH_LPAREN) begin
        vb      = 1'b1;
        tb.kind = KIND_LPAREN;
      end else if (char_i == CH_RPAREN) begin
        vb      = 1'b1;
        tb.kind = KIND_RPAREN;
      end else if (char_i == CH_PLUS) begin
        vb      = 1'b1;
        tb.kind = KIND_PLUS;
      end else if (char_i == CH_MINUS) begin
        vb      = 1'b1;
        tb.kind = KIND_MINUS;
      end else if (char_i == CH_SLASH) begin
        vb      = 1'b1;
        tb.kind = KIND_DIV;
      end else if (char_i == CH_CARET) begin
        vb      = 1'b1;
        tb.kind = KIND_POW;
      end else if (char_i == CH_STAR) begin
        mode_mid = MODE_STAR;
        s_mid    = pos_q;
      end else if (digit_hit) begin
        mode_mid = MODE_INT;
        s_mid    = pos_q;
      end else begin
        // skipped character
      end
    end
  end

  // Flush on the last character
  always_comb begin
    vc = 1'b0;
    tc = '{kind: KIND_NUM, start: TOK_W'(s_mid), length: TOK_W'(1), run_last: 1'b0};
    if (is_last_i) begin
      unique case (mode_mid)
        MODE_STAR: begin
          vc      = 1'b1;
          tc.kind = KIND_MULT;
        end
        MODE_INT, MODE_FRAC: begin
          vc        = 1'b1;
          tc.length = clamp_len(raw_up_mid);
        end
        MODE_INT_DOT: begin
          vc        = 1'b1;
          tc.length = clamp_len(raw_eq_mid);
        end
        default: ;
      endcase
    end
  end

  // At most two of the three candidates fire; b and c never together
  always_comb begin
    cnt         = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
    push_o.cnt  = accept_i ? cnt : 2'd0;
    push_o.tok0 = va ? ta : (vb ? tb : tc);
    push_o.tok1 = va ? (vb ? tb : tc) : tc;
    push_o.tok0.run_last = (cnt == 2'd1);
    push_o.tok1.run_last = 1'b1;
  end

  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    pos_d  = pos_q;
    if (accept_i) begin
      if (is_last_i) begin
        mode_d = MODE_IDLE;
        pend_d = '0;
        pos_d  = '0;
      end else begin
        mode_d = mode_mid;
        pend_d = s_mid;
        pos_d  = (pos_q == '1) ? pos_q : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pend_q <= '0;
      pos_q  <= '0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      pos_q  <= pos_d;
    end
  end

  a_pend_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= pos_q)
    else $error("held token starts after current position");

  a_last_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_last_i |=> pos_q == '0 && mode_q == MODE_IDLE)
    else $error("scanner not rewound after last character");

  a_hold_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_last_i |-> push_o.cnt != 2'd0 || mode_mid == MODE_IDLE)
    else $error("pending token not flushed on last character");

endmodule

`default_nettype wire

### rtl/core/ael_token_fifo.sv
// Token queue: takes up to two tokens per cycle, delivers one per transfer.
// Uses ael_pkg for the token format.
`default_nettype none

module ael_token_fifo
  import ael_pkg::*;
#(
  parameter int DEPTH = AEL_QUEUE_DEPTH
) (
  input  wire  logic  clk_i,
  input  wire  logic  rst_ni,
  input  wire  push_t push_i,
  output logic        room2_o,
  output logic        valid_o,
  input  wire  logic  stall_i,
  output token_t      tok_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, wr_nxt, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_nxt  = ptr_inc(wr_q);
  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_q];
  assign pop     = valid_o && !stall_i;
  assign room2_o = (cnt_q <= CNT_W'(DEPTH - 2));

  always_comb begin
    wr_d = wr_q;
    unique case (push_i.cnt)
      2'd1:    wr_d = wr_nxt;
      2'd2:    wr_d = ptr_inc(wr_nxt);
      default: ;
    endcase
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CNT_W'(push_i.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !room2_o |-> push_i.cnt == 2'd0)
    else $error("token queue overflow");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 && push_i.cnt != 2'd0 |=> valid_o)
    else $error("pushed token not presented");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("token queue count out of range");

endmodule

`default_nettype wire

### rtl/core/arith_expr_lexer.sv
// Arithmetic expression lexer, top level.
// Instantiates ael_scan and ael_token_fifo; uses ael_pkg.
//
// Usage:
//   Input channel: one source character per transfer (char_in_i), with
//   is_last_i marking the final character of a source. Output channel: one
//   token per transfer: kind, start position, length, and run_last on the
//   last token caused by a given character.
//   Latency: with the queue empty, a token is offered on out_valid_o the
//   cycle after the character that causes it is transferred in; otherwise
//   it waits behind the tokens already queued.
//   Throughput: one character per cycle. A character emits zero, one or two
//   tokens, but each token covers characters of its own, so tokens never
//   outrun characters; the four-entry queue absorbs the two-token bursts and
//   the input only stalls when the receiver does.
//   in_stall_o rises when the queue has fewer than two free entries; a
//   stalled receiver therefore backs up into the input after the queue fills.
//   '*' and numbers are held in the scanner until the next character decides
//   them; the last character flushes them and rewinds position to zero.
//   Reset: queue empty, scanner idle, position zero.
`default_nettype none

module arith_expr_lexer
  import ael_pkg::*;
#(
  parameter int POS_WIDTH = AEL_POS_WIDTH
) (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             in_valid_i,
  output logic                   in_stall_o,
  input  wire  logic [7:0]       char_in_i,
  input  wire  logic             is_last_i,
  output logic                   out_valid_o,
  input  wire  logic             out_stall_i,
  output logic [2:0]             token_kind_o,
  output logic [TOK_W-1:0]       token_start_o,
  output logic [TOK_W-1:0]       token_length_o,
  output logic                   run_last_o
);

  logic   accept;
  logic   room2;
  push_t  push;
  token_t head;

  // Stall purely from queue occupancy, so it never depends on in_valid_i
  assign in_stall_o = !room2;
  assign accept     = in_valid_i && !in_stall_o;

  ael_scan #(
    .POS_WIDTH(POS_WIDTH)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .char_i    (char_in_i),
    .is_last_i (is_last_i),
    .push_o    (push)
  );

  ael_token_fifo #(
    .DEPTH(AEL_QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .tok_o   (head)
  );

  assign token_kind_o   = head.kind;
  assign token_start_o  = head.start;
  assign token_length_o = head.length;
  assign run_last_o     = head.run_last;

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for arith_expr_lexer: directed rows, then random expressions.
// Each accepted token is checked against typed expectations or a behavioral tokenizer kept in this file.
// Depends on ael_pkg and the arith_expr_lexer RTL.
`timescale 1ns / 1ps

module tb_top;
  import ael_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  // Highest value the position counter reaches
  localparam longint unsigned POS_LIMIT = (64'd1 << AEL_POS_WIDTH) - 1;
  // Cycles with no transfer on either channel before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 630;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       char_in_i;
  logic             is_last_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [2:0]       token_kind_o;
  logic [TOK_W-1:0] token_start_o;
  logic [TOK_W-1:0] token_length_o;
  logic             run_last_o;

  arith_expr_lexer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .run_last_o     (run_last_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Behavioral tokenizer: mirrors the scanner state and yields the tokens that
  // one character causes, in emission order.
  // ---------------------------------------------------------------------------
  mode_e           lex_mode_q;
  longint unsigned pend_start_q;   // start of the held '*' or number
  longint unsigned char_pos_q;     // position of the next character
  token_t          step_toks[$];   // tokens caused by the current character
  token_t          token_q[$];     // tokens still owed by the DUT, oldest first

  int send_idle_pct;
  int recv_stall_pct;
  int error_count = 0;
  int quiet_cycles = 0;

  // Token with start masked to 16 bits and length held to 1..LEN_MAX
  function automatic token_t make_tok(kind_e k, longint unsigned start, longint len, logic rl);
    token_t t;
    t.kind  = k;
    t.start = start[TOK_W-1:0];
    if (len < 1)
      t.length = TOK_W'(1);
    else if (len > LEN_MAX)
      t.length = TOK_W'(LEN_MAX);
    else
      t.length = len[TOK_W-1:0];
    t.run_last = rl;
    return t;
  endfunction

  function automatic bit char_is_num(logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  task automatic lex_reset();
    lex_mode_q   = MODE_IDLE;
    pend_start_q = 0;
    char_pos_q   = 0;
  endtask

  task automatic lex_char(input logic [7:0] ch, input logic last);
    longint unsigned p;
    longint unsigned s;
    longint          dp;
    bit              taken;
    token_t          t;
    p     = char_pos_q;
    s     = pend_start_q;
    dp    = longint'(p) - longint'(s);
    taken = 1'b0;
    step_toks.delete();

    // First let the held token see this character
    case (lex_mode_q)
      MODE_STAR: begin
        if (ch == CH_STAR) begin
          step_toks.push_back(make_tok(KIND_POW, s, 2, 1'b0));
          taken = 1'b1;
        end else begin
          step_toks.push_back(make_tok(KIND_MULT, s, 1, 1'b0));
        end
        lex_mode_q = MODE_IDLE;
      end
      MODE_INT: begin
        if (char_is_num(ch)) begin
          taken = 1'b1;
        end else if (ch == CH_DOT) begin
          lex_mode_q = MODE_INT_DOT;
          taken      = 1'b1;
        end else begin
          step_toks.push_back(make_tok(KIND_NUM, s, dp, 1'b0));
          lex_mode_q = MODE_IDLE;
        end
      end
      MODE_INT_DOT: begin
        if (char_is_num(ch)) begin
          lex_mode_q = MODE_FRAC;
          taken      = 1'b1;
        end else begin
          // dot did not join: number ends before it, dot is rescanned below
          step_toks.push_back(make_tok(KIND_NUM, s, dp - 1, 1'b0));
          lex_mode_q = MODE_IDLE;
        end
      end
      MODE_FRAC: begin
        if (char_is_num(ch)) begin
          taken = 1'b1;
        end else begin
          step_toks.push_back(make_tok(KIND_NUM, s, dp, 1'b0));
          lex_mode_q = MODE_IDLE;
        end
      end
      default: lex_mode_q = MODE_IDLE;
    endcase

    // Then scan the character afresh if nothing took it
    if (!taken) begin
      case (ch)
        CH_LPAREN: step_toks.push_back(make_tok(KIND_LPAREN, p, 1, 1'b0));
        CH_RPAREN: step_toks.push_back(make_tok(KIND_RPAREN, p, 1, 1'b0));
        CH_PLUS:   step_toks.push_back(make_tok(KIND_PLUS, p, 1, 1'b0));
        CH_MINUS:  step_toks.push_back(make_tok(KIND_MINUS, p, 1, 1'b0));
        CH_SLASH:  step_toks.push_back(make_tok(KIND_DIV, p, 1, 1'b0));
        CH_CARET:  step_toks.push_back(make_tok(KIND_POW, p, 1, 1'b0));
        CH_STAR: begin
          lex_mode_q   = MODE_STAR;
          pend_start_q = p;
        end
        default: begin
          if (char_is_num(ch)) begin
            lex_mode_q   = MODE_INT;
            pend_start_q = p;
          end
        end
      endcase
    end

    if (last) begin
      // flush whatever is held, then back to the reset state
      s  = pend_start_q;
      dp = longint'(p) - longint'(s);
      if (lex_mode_q == MODE_STAR)
        step_toks.push_back(make_tok(KIND_MULT, s, 1, 1'b0));
      else if (lex_mode_q == MODE_INT || lex_mode_q == MODE_FRAC)
        step_toks.push_back(make_tok(KIND_NUM, s, dp + 1, 1'b0));
      else if (lex_mode_q == MODE_INT_DOT)
        step_toks.push_back(make_tok(KIND_NUM, s, dp, 1'b0));
      lex_reset();
    end else begin
      char_pos_q = (p < POS_LIMIT) ? p + 1 : p;
    end

    if (step_toks.size() > 0) begin
      t = step_toks[step_toks.size() - 1];
      t.run_last = 1'b1;
      step_toks[step_toks.size() - 1] = t;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Called at a rising edge; returns at the edge of the transfer.
  // Acceptance is judged at the falling edge, where all inputs have settled.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= ch;
    is_last_i  <= last;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  // Transfer one character and queue the tokens it owes
  task automatic feed(input logic [7:0] ch, input logic last);
    send_char(ch, last);
    lex_char(ch, last);
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endtask

  // Hold the input off until every owed token has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random source text: mostly well-formed expressions with random numbers,
  // operators and spacing; some noise bytes and broken tails mixed in.
  // ---------------------------------------------------------------------------
  logic [7:0] src_chars[$];

  task automatic build_source();
    int parts;
    int ndig;
    logic [7:0] ops[7];
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_STAR, CH_MINUS};
    src_chars.delete();
    parts = $urandom_range(1, 9);
    for (int k = 0; k < parts; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          ndig = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
          repeat (ndig) src_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 9) < 4) begin
            src_chars.push_back(CH_DOT);
            repeat ($urandom_range(1, 3)) src_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
        end
        4, 5, 6: begin
          src_chars.push_back(ops[$urandom_range(0, 6)]);
          if ($urandom_range(0, 5) == 0) src_chars.push_back(CH_STAR);  // power operator if a '*' came before
        end
        7: src_chars.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
        8: src_chars.push_back(CH_SPACE);
        default: src_chars.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    // broken tail: dangling dot or star
    if ($urandom_range(0, 7) == 0) src_chars.push_back($urandom_range(0, 1) ? CH_DOT : CH_STAR);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows. Expectations are typed in where they are plain to see;
  // rows with typed == 0 are checked against the tokenizer above.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         typed;
    int         n_tok;
    token_t     t0;
    token_t     t1;
  } dir_row_t;

  localparam int N_ROWS = 25;
  localparam token_t NO_TOK = '0;
  dir_row_t dir_rows[N_ROWS];

  initial begin
    dir_rows = '{
      // every single-character token emitted at once, from reset, positions 0..5
      '{CH_LPAREN, 1'b0, 1'b1, 1, make_tok(KIND_LPAREN, 0, 1, 1'b1), NO_TOK},
      '{CH_RPAREN, 1'b0, 1'b1, 1, make_tok(KIND_RPAREN, 1, 1, 1'b1), NO_TOK},
      '{CH_PLUS,   1'b0, 1'b1, 1, make_tok(KIND_PLUS, 2, 1, 1'b1), NO_TOK},
      '{CH_MINUS,  1'b0, 1'b1, 1, make_tok(KIND_MINUS, 3, 1, 1'b1), NO_TOK},
      '{CH_SLASH,  1'b0, 1'b1, 1, make_tok(KIND_DIV, 4, 1, 1'b1), NO_TOK},
      '{CH_CARET,  1'b0, 1'b1, 1, make_tok(KIND_POW, 5, 1, 1'b1), NO_TOK},
      // '**' is power, '*(' is multiply then paren
      '{CH_STAR,   1'b0, 1'b1, 0, NO_TOK, NO_TOK},
      '{CH_STAR,   1'b0, 1'b1, 1, make_tok(KIND_POW, 6, 2, 1'b1), NO_TOK},
      '{CH_STAR,   1'b0, 1'b1, 0, NO_TOK, NO_TOK},
      '{CH_LPAREN, 1'b0, 1'b1, 2, make_tok(KIND_MULT, 8, 1, 1'b0),
                                  make_tok(KIND_LPAREN, 9, 1, 1'b1)},
      // "12.5" ended by a dot that joins nothing
      '{CH_ZERO + 8'd1, 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      '{CH_ZERO + 8'd2, 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      '{CH_DOT,         1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      '{CH_ZERO + 8'd5, 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      '{CH_DOT,         1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      // "9." then '+': number drops the dot, '+' is scanned afresh
      '{CH_NINE,        1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      '{CH_DOT,         1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      '{CH_PLUS,        1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      // NUL is skipped
      '{8'h00,          1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      // dot as the final character flushes the number without it
      '{CH_ZERO + 8'd7, 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      '{CH_DOT,         1'b1, 1'b0, 0, NO_TOK, NO_TOK},
      // one- and two-character sources: position restarts at zero each time
      '{CH_STAR,   1'b1, 1'b1, 1, make_tok(KIND_MULT, 0, 1, 1'b1), NO_TOK},
      '{CH_ZERO,   1'b1, 1'b1, 1, make_tok(KIND_NUM, 0, 1, 1'b1), NO_TOK},
      '{CH_STAR,   1'b0, 1'b0, 0, NO_TOK, NO_TOK},
      '{CH_STAR,   1'b1, 1'b1, 1, make_tok(KIND_POW, 0, 2, 1'b1), NO_TOK}
    };
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall, driven at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);

  // Check each token transfer against the oldest owed token. Sampled at the
  // falling edge so the values are those the next rising edge transfers.
  always @(negedge clk_i) begin : token_check
    token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token kind %0d start %0d length %0d", $time,
                 token_kind_o, token_start_o, token_length_o);
        error_count++;
      end else begin
        want = token_q.pop_front();
        if (token_kind_o != want.kind) begin
          $display("%0t: token_kind expected %0d got %0d", $time, want.kind, token_kind_o);
          error_count++;
        end
        if (token_start_o != want.start) begin
          $display("%0t: token_start expected %0d got %0d", $time, want.start, token_start_o);
          error_count++;
        end
        if (token_length_o != want.length) begin
          $display("%0t: token_length expected %0d got %0d", $time, want.length,
                   token_length_o);
          error_count++;
        end
        if (run_last_o != want.run_last) begin
          $display("%0t: run_last expected %0d got %0d", $time, want.run_last, run_last_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either side means a hang
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d tokens owed", $time, quiet_cycles,
               token_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase_items;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    char_in_i      = '0;
    is_last_i      = 1'b0;
    send_idle_pct  = 15;
    recv_stall_pct = 69;
    lex_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (int r = 0; r < N_ROWS; r++) begin
      send_char(dir_rows[r].ch, dir_rows[r].last);
      lex_char(dir_rows[r].ch, dir_rows[r].last);
      if (dir_rows[r].typed) begin
        if (dir_rows[r].n_tok >= 1) token_q.push_back(dir_rows[r].t0);
        if (dir_rows[r].n_tok == 2) token_q.push_back(dir_rows[r].t1);
      end else begin
        foreach (step_toks[i]) token_q.push_back(step_toks[i]);
      end
    end
    // sender holds off until every token is out
    drain();

    // random expressions: light sender idling with heavy receiver stall,
    // then the reverse, then full rate both ways
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 15 : (phase == 1) ? 69 : 0;
      recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 15 : 0;
      phase_items    = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_source();
        foreach (src_chars[i]) feed(src_chars[i], i == src_chars.size() - 1);
        phase_items += src_chars.size();
      end
      drain();
    end

    // give stray tokens a chance to show
    repeat (20) @(posedge clk_i);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
rtl/core/ael_pkg.sv
rtl/core/ael_scan.sv
rtl/core/ael_token_fifo.sv
rtl/core/arith_expr_lexer.sv
test/tb_top.sv
